// ===== sv/fresnel_reflectance_assert.svh =====
// ----------------------------------------------------------------------------
// fresnel reflectance assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FRESNEL_REFLECTANCE_ASSERT_SVH
`define FRESNEL_REFLECTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define FRSN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frsn assertion failed");
`define FRSN_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("frsn implication failed");
`else
`define FRSN_ASSERT(lbl, prop)
`define FRSN_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// ===== sv/frsn_pkg.sv =====
// ----------------------------------------------------------------------------
// frsn_pkg
// shared types and constants of the fresnel reflectance pipeline
// ----------------------------------------------------------------------------
package frsn_pkg;

  localparam int DIR_FRAC_BITS = 14;
  localparam int DOT_FRAC      = 2 * DIR_FRAC_BITS;
  localparam int C30_SH_R      = (DOT_FRAC > 30) ? DOT_FRAC - 30 : 0;
  localparam int C30_SH_L      = (DOT_FRAC < 30) ? 30 - DOT_FRAC : 0;

  localparam int SQ_STEPS      = 31;
  localparam int DIV_T_STEPS   = 30;
  localparam int NORM_STEPS    = 15;
  localparam int COEF_BITS     = 32;

  localparam logic [14:0] IDX_ONE  = 15'd4096;
  localparam logic [16:0] REFL_ONE = 17'd65536;

  typedef logic [60:0] rad_t;
  typedef logic [30:0] root_t;

  typedef struct packed {
    logic signed [15:0] inc_x;
    logic signed [15:0] inc_y;
    logic signed [15:0] inc_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        index_ratio;
  } frsn_in_t;

  typedef struct packed {
    logic [16:0] reflectance;
    logic        total_internal;
  } frsn_out_t;

  typedef struct packed {
    logic [30:0] c30;
    logic [14:0] ei;
    logic [14:0] et;
    logic        tir;
  } frsn_side_t;

endpackage

// ===== sv/fresnel_reflectance.sv =====
// throughput: one beat per cycle; the pipeline moves as a whole and stalls
// only once its output register and one skid entry both hold results
// the two 31-stage square roots and the 32-stage coefficient dividers set the depth
// reset clears all valid bits, those of the output and skid registers included
// ----------------------------------------------------------------------------
// fresnel_reflectance
// unpolarized fresnel reflectance of a dielectric surface, fixed point
// ----------------------------------------------------------------------------
`include "fresnel_reflectance_assert.svh"

module fresnel_reflectance (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frsn_pkg::frsn_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frsn_pkg::frsn_out_t out_data_o
);
  import frsn_pkg::*;

  logic       en;
  logic       fr_v, sa_v, dv_v, sb_v, cf_v;
  rad_t       fr_rad, dv_rad;
  frsn_side_t fr_side, sa_side, dv_side, sb_side;
  root_t      sin_i, cos_t;
  frsn_out_t  cf_data;

  logic       out_v_q, out_v_d, skid_v_q, skid_v_d;
  frsn_out_t  out_q, out_d, skid_q, skid_d;

  assign en = !skid_v_q;

  frsn_front u_front (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i, .in_data_i,
    .out_valid_o(fr_v), .rad_o(fr_rad), .side_o(fr_side)
  );

  frsn_sqrt u_sqrt_sin (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(fr_v), .rad_i(fr_rad), .side_i(fr_side),
    .out_valid_o(sa_v), .root_o(sin_i), .side_o(sa_side)
  );

  frsn_div u_div (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(sa_v), .sin_i(sin_i), .side_i(sa_side),
    .out_valid_o(dv_v), .rad_o(dv_rad), .side_o(dv_side)
  );

  frsn_sqrt u_sqrt_cos (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(dv_v), .rad_i(dv_rad), .side_i(dv_side),
    .out_valid_o(sb_v), .root_o(cos_t), .side_o(sb_side)
  );

  frsn_coef u_coef (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(sb_v), .cos_i(cos_t), .side_i(sb_side),
    .out_valid_o(cf_v), .out_data_o(cf_data)
  );

  // output register with one skid entry
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (cf_v) begin
      if (!out_v_q || out_ready_i) begin
        out_d   = cf_data;
        out_v_d = 1'b1;
      end else begin
        skid_d   = cf_data;
        skid_v_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `FRSN_ASSERT_IMP(a_tir_full, out_valid_o && out_data_o.total_internal, out_data_o.reflectance == REFL_ONE)
  `FRSN_ASSERT_IMP(a_refl_max, out_valid_o, out_data_o.reflectance <= REFL_ONE)
  `FRSN_ASSERT_IMP(a_ready_empty, !out_valid_o, in_ready_o)
  `FRSN_ASSERT_IMP(a_skid_order, skid_v_q, out_v_q)

endmodule

// ===== sv/frsn_front.sv =====
// ----------------------------------------------------------------------------
// frsn_front
// dot product, clamp, index swap and sine radicand, four stages
// ----------------------------------------------------------------------------
module frsn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  frsn_pkg::frsn_in_t   in_data_i,
  output logic                 out_valid_o,
  output frsn_pkg::rad_t       rad_o,
  output frsn_pkg::frsn_side_t side_o
);
  import frsn_pkg::*;

  logic [3:0]         vld_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [14:0]        n_q;
  logic signed [33:0] dot;
  logic [33:0]        magn;
  logic [63:0]        magc;
  logic [63:0]        c30w;
  logic               ray_inside;
  frsn_side_t         s1_d, s1_q, s2_q, s3_q;
  logic [61:0]        sq_q;
  rad_t               rad_q;

  always_comb begin
    dot        = 34'(px_q) + 34'(py_q) + 34'(pz_q);
    ray_inside = !dot[33] && (dot != '0);
    magn       = dot[33] ? 34'(-dot) : 34'(dot);
    magc       = 64'(magn);
    if (magc > (64'd1 << DOT_FRAC)) begin
      magc = 64'd1 << DOT_FRAC;
    end
    c30w     = (magc >> C30_SH_R) << C30_SH_L;
    s1_d.c30 = c30w[30:0];
    s1_d.ei  = ray_inside ? n_q : IDX_ONE;
    s1_d.et  = ray_inside ? IDX_ONE : n_q;
    s1_d.tir = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= $signed(in_data_i.inc_x) * $signed(in_data_i.norm_x);
      py_q  <= $signed(in_data_i.inc_y) * $signed(in_data_i.norm_y);
      pz_q  <= $signed(in_data_i.inc_z) * $signed(in_data_i.norm_z);
      // zero index is taken as one lsb
      n_q   <= (in_data_i.index_ratio == '0) ? 15'd1 : in_data_i.index_ratio;
      s1_q  <= s1_d;
      sq_q  <= 62'(s1_q.c30) * 62'(s1_q.c30);
      s2_q  <= s1_q;
      rad_q <= 61'((62'd1 << 60) - sq_q);
      s3_q  <= s2_q;
    end
  end

  assign out_valid_o = vld_q[3];
  assign rad_o       = rad_q;
  assign side_o      = s3_q;

endmodule

// ===== sv/frsn_sqrt.sv =====
// ----------------------------------------------------------------------------
// frsn_sqrt
// floor square root of a radicand up to 2^60, one result bit per stage
// ----------------------------------------------------------------------------
module frsn_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  frsn_pkg::rad_t       rad_i,
  input  frsn_pkg::frsn_side_t side_i,
  output logic                 out_valid_o,
  output frsn_pkg::root_t      root_o,
  output frsn_pkg::frsn_side_t side_o
);
  import frsn_pkg::*;

  logic [SQ_STEPS-1:0] vld_q;
  logic [61:0]         rem_q  [SQ_STEPS];
  logic [61:0]         r_q    [SQ_STEPS];
  frsn_side_t          sd_q   [SQ_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQ_STEPS-2:0], in_valid_i};
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam logic [61:0] BitW = 62'd1 << (60 - 2 * j);
    logic [61:0] vi, ri, t, vn, rn;
    frsn_side_t  si;
    if (j == 0) begin : g_first
      assign vi = 62'(rad_i);
      assign ri = '0;
      assign si = side_i;
    end else begin : g_next
      assign vi = rem_q[j-1];
      assign ri = r_q[j-1];
      assign si = sd_q[j-1];
    end
    always_comb begin
      t = ri + BitW;
      if (vi >= t) begin
        vn = vi - t;
        rn = (ri >> 1) + BitW;
      end else begin
        vn = vi;
        rn = ri >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= vn;
        r_q[j]   <= rn;
        sd_q[j]  <= si;
      end
    end
  end

  assign out_valid_o = vld_q[SQ_STEPS-1];
  assign root_o      = r_q[SQ_STEPS-1][30:0];
  assign side_o      = sd_q[SQ_STEPS-1];

endmodule

// ===== sv/frsn_div.sv =====
// ----------------------------------------------------------------------------
// frsn_div
// snell's law: sin_t = sin_i * ei / et with total internal reflection test,
// then the cosine radicand for the transmitted angle
// ----------------------------------------------------------------------------
module frsn_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  frsn_pkg::root_t      sin_i,
  input  frsn_pkg::frsn_side_t side_i,
  output logic                 out_valid_o,
  output frsn_pkg::rad_t       rad_o,
  output frsn_pkg::frsn_side_t side_o
);
  import frsn_pkg::*;

  localparam int N = DIV_T_STEPS + 4;

  logic [N-1:0] vld_q;
  logic [45:0]  prod_q;
  frsn_side_t   s0_q, s1_d, s1_q;
  logic [45:0]  rem0_q;
  logic [45:0]  rem_q [DIV_T_STEPS];
  logic [29:0]  q_q   [DIV_T_STEPS];
  frsn_side_t   sd_q  [DIV_T_STEPS];
  logic [59:0]  sq_q;
  frsn_side_t   sq_side_q, out_side_q;
  rad_t         rad_q;

  always_comb begin
    s1_d     = s0_q;
    // sine reaching one means total internal reflection
    s1_d.tir = prod_q >= 46'({s0_q.et, 30'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q     <= 46'(sin_i) * 46'(side_i.ei);
      s0_q       <= side_i;
      rem0_q     <= prod_q;
      s1_q       <= s1_d;
      sq_q       <= 60'(q_q[DIV_T_STEPS-1]) * 60'(q_q[DIV_T_STEPS-1]);
      sq_side_q  <= sd_q[DIV_T_STEPS-1];
      rad_q      <= (61'd1 << 60) - 61'(sq_q);
      out_side_q <= sq_side_q;
    end
  end

  for (genvar k = 0; k < DIV_T_STEPS; k++) begin : g_step
    localparam int B = DIV_T_STEPS - 1 - k;
    logic [45:0] ri, dsh, rn;
    logic [29:0] qi, qn;
    frsn_side_t  si;
    if (k == 0) begin : g_first
      assign ri = rem0_q;
      assign qi = '0;
      assign si = s1_q;
    end else begin : g_next
      assign ri = rem_q[k-1];
      assign qi = q_q[k-1];
      assign si = sd_q[k-1];
    end
    always_comb begin
      dsh = 46'(si.et) << B;
      rn  = ri;
      qn  = qi;
      if (ri >= dsh) begin
        rn    = ri - dsh;
        qn[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rn;
        q_q[k]   <= qn;
        sd_q[k]  <= si;
      end
    end
  end

  assign out_valid_o = vld_q[N-1];
  assign rad_o       = rad_q;
  assign side_o      = out_side_q;

endmodule

// ===== sv/frsn_coef.sv =====
// ----------------------------------------------------------------------------
// frsn_coef
// s and p amplitude coefficients, their squares and the averaged reflectance
// ----------------------------------------------------------------------------
module frsn_coef (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  frsn_pkg::root_t      cos_i,
  input  frsn_pkg::frsn_side_t side_i,
  output logic                 out_valid_o,
  output frsn_pkg::frsn_out_t  out_data_o
);
  import frsn_pkg::*;

  localparam int N = NORM_STEPS + COEF_BITS + 4;

  logic [N-1:0] vld_q;
  logic [N-1:0] tir_q;

  // channel 0 is p, channel 1 is s
  logic [45:0]           a_q  [NORM_STEPS+1][2];
  logic [45:0]           b_q  [NORM_STEPS+1][2];
  logic [30:0]           d_q  [2];
  logic [30:0]           df_q [2];
  logic [61:0]           rem_q[COEF_BITS][2];
  logic [30:0]           dv_q [COEF_BITS][2];
  logic [COEF_BITS-1:0]  q_q  [COEF_BITS][2];
  logic [COEF_BITS-1:0]  dz_q [2];
  logic [63:0]           sq_q [2];
  logic [64:0]           sum;
  logic [64:0]           refl;
  frsn_out_t             res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tir_q      <= {tir_q[N-2:0], side_i.tir};
      a_q[0][0]  <= 46'(side_i.et) * 46'(side_i.c30);
      b_q[0][0]  <= 46'(side_i.ei) * 46'(cos_i);
      a_q[0][1]  <= 46'(side_i.ei) * 46'(side_i.c30);
      b_q[0][1]  <= 46'(side_i.et) * 46'(cos_i);
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_ch
    for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
      logic [46:0] s;
      assign s = 47'(a_q[j-1][c]) + 47'(b_q[j-1][c]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (s >= (47'd1 << 31)) begin
            a_q[j][c] <= a_q[j-1][c] >> 1;
            b_q[j][c] <= b_q[j-1][c] >> 1;
          end else begin
            a_q[j][c] <= a_q[j-1][c];
            b_q[j][c] <= b_q[j-1][c];
          end
        end
      end
    end

    logic [30:0] an, bn;
    assign an = a_q[NORM_STEPS][c][30:0];
    assign bn = b_q[NORM_STEPS][c][30:0];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[c]  <= an + bn;
        df_q[c] <= (an > bn) ? an - bn : bn - an;
      end
    end

    for (genvar k = 0; k < COEF_BITS; k++) begin : g_div
      localparam int B = COEF_BITS - 1 - k;
      logic [61:0]          ri, dsh, rn;
      logic [30:0]          di;
      logic [COEF_BITS-1:0] qi, qn;
      logic                 zi;
      if (k == 0) begin : g_first
        assign ri = {df_q[c], 31'b0};
        assign di = d_q[c];
        assign qi = '0;
        assign zi = (d_q[c] == '0);
      end else begin : g_next
        assign ri = rem_q[k-1][c];
        assign di = dv_q[k-1][c];
        assign qi = q_q[k-1][c];
        assign zi = dz_q[c][k-1];
      end
      always_comb begin
        dsh = 62'(di) << B;
        rn  = ri;
        qn  = qi;
        if (ri >= dsh) begin
          rn    = ri - dsh;
          qn[B] = 1'b1;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][c] <= rn;
          dv_q[k][c]  <= di;
          q_q[k][c]   <= qn;
          dz_q[c][k]  <= zi;
        end
      end
    end

    logic [COEF_BITS-1:0] coef;
    // empty denominator counts as full reflection
    assign coef = dz_q[c][COEF_BITS-1] ? (COEF_BITS'(1) << 31) : q_q[COEF_BITS-1][c];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[c] <= 64'(coef) * 64'(coef);
      end
    end
  end

  always_comb begin
    sum  = 65'(sq_q[0]) + 65'(sq_q[1]) + (65'd1 << 46);
    refl = sum >> 47;
    if (tir_q[N-2]) begin
      res_d.reflectance    = REFL_ONE;
      res_d.total_internal = 1'b1;
    end else begin
      res_d.reflectance    = (refl > 65'(REFL_ONE)) ? REFL_ONE : refl[16:0];
      res_d.total_internal = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = res_q;

endmodule
